@@ src/slm_pkg.sv @@
// ----------------------------------------------------------------------------
// slm_pkg
// shared types and codes of the sorted list merge unit
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int VALUE_W  = 32;
   localparam int OPCODE_W = 2;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH_A = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_B = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_START  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic push_a;   // append value to list a
      logic push_b;   // append value to list b
      logic start;    // rewind heads, load remaining count
      logic pop;      // emit the smaller head into the output register
      logic finish;   // merge done, clear both counts
   } slm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rem_zero;     // no element left to emit
      logic out_busy;     // output register holds an untaken result
      logic lists_empty;  // both counts are zero
   } slm_status_type;

endpackage

@@ src/slm_ram.sv @@
// ----------------------------------------------------------------------------
// slm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module slm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/slm_ctrl.sv @@
// ----------------------------------------------------------------------------
// slm_ctrl
// controller: request handshake, opcode decode and merge sequencing
// ----------------------------------------------------------------------------
module slm_ctrl
   import slm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [OPCODE_W-1:0] opcode,
   input  logic                rsp_tready,
   input  slm_status_type      status,
   output slm_cmd_type         cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.push_a = accept & (opcode == OP_PUSH_A);
            cmd.push_b = accept & (opcode == OP_PUSH_B);
            cmd.start  = accept & (opcode == OP_START);
            if (cmd.start) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (status.rem_zero) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.pop = ~status.out_busy | rsp_tready;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/slm_dp.sv @@
// ----------------------------------------------------------------------------
// slm_dp
// datapath: two list stores, counts, head pointers, compare and output register
// ----------------------------------------------------------------------------
module slm_dp
   import slm_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  slm_cmd_type        cmd,
   output slm_status_type     status,
   input  logic [VALUE_W-1:0] value,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [VALUE_W-1:0] merged_value,
   output logic               last
);

   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int REM_W  = $clog2(2 * LIST_DEPTH + 1);

   logic [CNT_W-1:0]   count_a_ff, count_a_in;
   logic [CNT_W-1:0]   count_b_ff, count_b_in;
   logic [CNT_W-1:0]   ptr_a_ff, ptr_a_in;
   logic [CNT_W-1:0]   ptr_b_ff, ptr_b_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;

   logic               wr_a, wr_b;
   logic [VALUE_W-1:0] head_a, head_b;
   logic               sel_a;

   assign wr_a = cmd.push_a & (count_a_ff < CNT_W'(LIST_DEPTH));
   assign wr_b = cmd.push_b & (count_b_ff < CNT_W'(LIST_DEPTH));

   slm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[ADDR_W-1:0]),
      .wr_data (value),
      .rd_addr (ptr_a_in[ADDR_W-1:0]),
      .rd_data (head_a)
   );

   slm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[ADDR_W-1:0]),
      .wr_data (value),
      .rd_addr (ptr_b_in[ADDR_W-1:0]),
      .rd_data (head_b)
   );

   // list a wins ties, which keeps the merge stable
   assign sel_a = (ptr_a_ff < count_a_ff) &&
                  ((ptr_b_ff >= count_b_ff) || ($signed(head_a) <= $signed(head_b)));

   always_comb begin
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ptr_a_in     = ptr_a_ff;
      ptr_b_in     = ptr_b_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      if (wr_a) begin
         count_a_in = count_a_ff + CNT_W'(1);
      end
      if (wr_b) begin
         count_b_in = count_b_ff + CNT_W'(1);
      end
      if (cmd.start) begin
         ptr_a_in = '0;
         ptr_b_in = '0;
         rem_in   = REM_W'(count_a_ff) + REM_W'(count_b_ff);
      end
      if (cmd.pop) begin
         out_valid_in = 1'b1;
         out_last_in  = (rem_ff == REM_W'(1));
         rem_in       = rem_ff - REM_W'(1);
         if (sel_a) begin
            out_data_in = head_a;
            ptr_a_in    = ptr_a_ff + CNT_W'(1);
         end else begin
            out_data_in = head_b;
            ptr_b_in    = ptr_b_ff + CNT_W'(1);
         end
      end
      if (cmd.finish) begin
         count_a_in = '0;
         count_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign status.rem_zero    = (rem_ff == '0);
   assign status.out_busy    = out_valid_ff;
   assign status.lists_empty = (count_a_ff == '0) && (count_b_ff == '0);

   assign rsp_tvalid   = out_valid_ff;
   assign merged_value = out_data_ff;
   assign last         = out_last_ff;

endmodule

@@ src/sorted_list_merge_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_list_merge_unit
// stable two-way merge of two ascending lists of signed 32-bit values
// ----------------------------------------------------------------------------
// Push transactions (tuser opcode push a / push b) append tdata to list a or
// list b, one per cycle while the unit is idle; a push to a full list is
// dropped. A start transaction merges both lists and streams the merged
// ascending sequence on rsp, smaller head first and list a first on a tie,
// with tlast on the final element; with both lists empty start produces
// nothing. Both lists are emptied once the merge is done. Opcode three is
// accepted and ignored. req_tready stays low for the whole merge, which
// delivers one result per cycle while rsp_tready stays high: each list
// store has one read port with a registered read, so each step reads one
// head per list and makes one signed compare.
// Results sit in an output register, so a new push is taken while the last
// result still waits.
// ----------------------------------------------------------------------------
module sorted_list_merge_unit
   import slm_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,   // [31:0] value
   input  logic [OPCODE_W-1:0] req_tuser,   // [1:0] opcode
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [VALUE_W-1:0]  rsp_tdata,   // [31:0] merged_value
   output logic                rsp_tlast
);

   slm_cmd_type    cmd;
   slm_status_type status;

   // controller: decode and merge sequencing
   slm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: list stores, pointers, compare, output register
   slm_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .value        (req_tdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .merged_value (rsp_tdata),
      .last         (rsp_tlast)
   );

   // a start transaction always moves the unit into the merge
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_tready)
      else $error("start did not enter merge");

   // no result is produced while requests are being taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !req_tready)
      else $error("pop while idle");

   // both lists are empty right after a merge ends
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> status.lists_empty)
      else $error("counts not cleared after merge");

endmodule

@@ bench/merge_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_checker
// watches both streams of the sorted list merge unit, keeps its own copy of
// the two lists, works out the merged sequence of every start transaction
// and compares each delivered result with it
// ----------------------------------------------------------------------------
module merge_checker
   import slm_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,
   input  logic [OPCODE_W-1:0] req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [VALUE_W-1:0]  rsp_tdata,
   input  logic                rsp_tlast,
   output int                  mismatch_count,
   output int                  awaited,
   output int                  merges_run,
   output int                  results_seen,
   output int                  pushes_dropped
);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } merged_elem_type;

   logic [VALUE_W-1:0] shadow_a [LIST_DEPTH];
   logic [VALUE_W-1:0] shadow_b [LIST_DEPTH];
   int                 fill_a;
   int                 fill_b;
   merged_elem_type    merged_due [$];

   // update the list copies and queue the merged sequence on a start
   task automatic apply_request(input logic [OPCODE_W-1:0] op,
                                input logic [VALUE_W-1:0] val);
      int ia;
      int ib;
      int total;
      int n;
      merged_elem_type elem;
      case (op)
         OP_PUSH_A: begin
            if (fill_a < LIST_DEPTH) begin
               shadow_a[fill_a] = val;
               fill_a++;
            end else begin
               pushes_dropped++;
            end
         end
         OP_PUSH_B: begin
            if (fill_b < LIST_DEPTH) begin
               shadow_b[fill_b] = val;
               fill_b++;
            end else begin
               pushes_dropped++;
            end
         end
         OP_START: begin
            ia    = 0;
            ib    = 0;
            total = fill_a + fill_b;
            for (n = 0; n < total; n++) begin
               // list a wins a tie, which keeps the merge stable
               if (ia < fill_a &&
                   (ib >= fill_b || $signed(shadow_a[ia]) <= $signed(shadow_b[ib]))) begin
                  elem.value = shadow_a[ia];
                  ia++;
               end else begin
                  elem.value = shadow_b[ib];
                  ib++;
               end
               elem.last = (n == total - 1);
               merged_due.push_back(elem);
            end
            fill_a = 0;
            fill_b = 0;
            merges_run++;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      merged_elem_type want;
      if (reset) begin
         fill_a         = 0;
         fill_b         = 0;
         merged_due.delete();
         mismatch_count = 0;
         merges_run     = 0;
         results_seen   = 0;
         pushes_dropped = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (merged_due.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%t: unexpected result value %0d last %0b, nothing awaited",
                           $realtime, $signed(rsp_tdata), rsp_tlast);
               mismatch_count++;
            end else begin
               want = merged_due.pop_front();
               if (rsp_tdata !== want.value || rsp_tlast !== want.last) begin
                  if (mismatch_count < 10)
                     $display("%t: result %0d expected value %0d last %0b, got value %0d last %0b",
                              $realtime, results_seen, $signed(want.value), want.last,
                              $signed(rsp_tdata), rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata);
      end
      awaited = merged_due.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the sorted list merge unit
// ----------------------------------------------------------------------------
// A directed opening covers a start on empty lists, the unused opcode, a list
// filled past its depth, ties and the signed extremes. Random merge jobs
// follow: ascending lists of random sizes and spreads pushed in random
// interleaving, mixed with random noise transactions. The sender runs in
// bursts with gaps, the receiver stalls on its own pattern, once holds off
// for a long stretch, and once the sender drains all results before going on.
// ----------------------------------------------------------------------------
module tb;
   import slm_pkg::*;

   localparam int                  LIST_DEPTH   = 16;
   localparam int                  ITEMS_TARGET = 350;
   localparam int                  HOLD_CYCLES  = 300;
   localparam int                  CYCLE_LIMIT  = 200000;
   localparam int                  SETTLE       = 2 * LIST_DEPTH + 8;
   // opcode three has no meaning and must be ignored
   localparam logic [OPCODE_W-1:0] OP_RESERVED  = 2'd3;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata;
   logic [OPCODE_W-1:0] req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [VALUE_W-1:0]  rsp_tdata;
   logic                rsp_tlast;

   int mismatch_count;
   int awaited;
   int merges_run;
   int results_seen;
   int pushes_dropped;

   int sent_count;
   int burst_left;
   int hold_token;
   int cycle_count;

   // values of the current merge job, one row per list
   logic [VALUE_W-1:0] job_vals [2][LIST_DEPTH+2];

   sorted_list_merge_unit #(
      .LIST_DEPTH (LIST_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   merge_checker #(
      .LIST_DEPTH (LIST_DEPTH)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .awaited        (awaited),
      .merges_run     (merges_run),
      .results_seen   (results_seen),
      .pushes_dropped (pushes_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // receiver: ready stretches, short stalls and chatter, plus a long
   // hold-off whenever the stimulus bumps hold_token
   initial begin : receiver
      int seg_left;
      int seg_mode;
      int hold_left;
      int tokens_seen;
      seg_left    = 0;
      seg_mode    = 0;
      hold_left   = 0;
      tokens_seen = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_token != tokens_seen) begin
            tokens_seen = hold_token;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 2);
               case (seg_mode)
                  0:       seg_left = $urandom_range(1, 40);
                  1:       seg_left = $urandom_range(1, 6);
                  default: seg_left = $urandom_range(4, 30);
               endcase
            end
            seg_left--;
            case (seg_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'b0;
               default: rsp_tready <= ($urandom_range(0, 2) != 0);
            endcase
         end
      end
   end

   // one request transaction; called at a falling edge, returns at one
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // end of burst: idle for a while with junk on the bus
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         req_tuser  <= OPCODE_W'($urandom_range(0, 3));
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // stop offering until every merged element has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (awaited == 0);
      @(negedge clock);
   endtask

   // list length: mostly short, sometimes full or past full
   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return $urandom_range(0, 6);
      else if (r < 9)
         return $urandom_range(7, LIST_DEPTH - 1);
      else
         return $urandom_range(LIST_DEPTH, LIST_DEPTH + 2);
   endfunction

   // fill one row of job_vals with n ascending signed values
   task automatic build_ascending(input int side, input int n);
      longint cur;
      int     step_max;
      int     k;
      step_max = ($urandom_range(0, 1) == 0) ? 3 : (1 << $urandom_range(4, 28));
      case ($urandom_range(0, 3))
         0:       cur = -64'sd2147483648;
         1:       cur = 64'sd2147483647 - longint'(n) * step_max;
         default: cur = longint'($signed($urandom()));
      endcase
      for (k = 0; k < n; k++) begin
         if (k > 0)
            cur += $urandom_range(0, step_max);
         if (cur > 64'sd2147483647)
            cur = 64'sd2147483647;
         if (cur < -64'sd2147483648)
            cur = -64'sd2147483648;
         job_vals[side][k] = cur[VALUE_W-1:0];
      end
   endtask

   // two sorted lists pushed in random interleaving, then a start
   task automatic run_merge_job();
      int len [2];
      int idx [2];
      int side;
      len[0] = pick_size();
      len[1] = pick_size();
      build_ascending(0, len[0]);
      build_ascending(1, len[1]);
      idx[0] = 0;
      idx[1] = 0;
      while (idx[0] < len[0] || idx[1] < len[1]) begin
         if (idx[0] >= len[0])
            side = 1;
         else if (idx[1] >= len[1])
            side = 0;
         else
            side = $urandom_range(0, 1);
         if ($urandom_range(0, 19) == 0)
            send_item(OP_RESERVED, $urandom());
         send_item(side ? OP_PUSH_B : OP_PUSH_A, job_vals[side][idx[side]]);
         idx[side]++;
      end
      send_item(OP_START, $urandom());
   endtask

   initial begin : stimulus
      int  k;
      bit  hold_done;
      bit  pause_done;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_PUSH_A;
      sent_count = 0;
      burst_left = 0;
      hold_token = 0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // start on two empty lists gives nothing; unused opcode is ignored
      send_item(OP_START, 32'hFFFF_FFFF);
      send_item(OP_RESERVED, 32'h5A5A_A5A5);
      // list a from the most negative to the most positive value, one past full
      for (k = 0; k <= LIST_DEPTH; k++) begin
         if (k == 0)
            send_item(OP_PUSH_A, 32'h8000_0000);
         else if (k == LIST_DEPTH - 1)
            send_item(OP_PUSH_A, 32'h7FFF_FFFF);
         else if (k == LIST_DEPTH)
            send_item(OP_PUSH_A, 32'h0000_0000);
         else
            send_item(OP_PUSH_A, 32'h8000_0000 + (k << 28));
      end
      // ties with list a at both extremes, and zero against negatives
      send_item(OP_PUSH_B, 32'h8000_0000);
      send_item(OP_PUSH_B, 32'h0000_0000);
      send_item(OP_PUSH_B, 32'h7FFF_FFFF);
      send_item(OP_START, 32'h0000_0000);
      // list b alone
      send_item(OP_PUSH_B, 32'hFFFF_FFFF);
      send_item(OP_START, 32'h1234_5678);

      while (sent_count < ITEMS_TARGET) begin
         // long receiver hold-off while requests keep coming
         if (!hold_done && sent_count >= 120) begin
            hold_token <= hold_token + 1;
            hold_done = 1'b1;
         end
         if (!pause_done && sent_count >= 230) begin
            drain_results();
            pause_done = 1'b1;
         end
         if ($urandom_range(0, 6) != 0)
            run_merge_job();
         else
            send_item(OPCODE_W'($urandom_range(0, 3)), $urandom());
      end
      // flush whatever is left in the lists
      send_item(OP_START, $urandom());
      req_tvalid <= 1'b0;

      wait (awaited == 0);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d request transactions and %0d merges, %0d results checked",
               sent_count, merges_run, results_seen);
      $display("%0d pushes dropped on a full list, %0d mismatches",
               pushes_dropped, mismatch_count);
      if (mismatch_count == 0 && awaited == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
